// File: src/rpn_pkg.sv
// Shared types and constants for the RPN stack calculator.
// No dependencies; used by rpn_alu, rpn_stack_calculator_unit and both dv/ files.
package rpn_pkg;

    localparam int DATA_W          = 32;
    localparam int MODE_W          = 3;
    localparam int DEPTH_OUT_W     = 7;
    localparam int STACK_DEPTH_DEF = 64;

    localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ADD  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SUB  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DIV  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_NEG  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_READ = 3'd6;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_FULL  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_ctrl;

endpackage

// File: src/rpn_mem.sv
// Operand stack storage below the two cached top entries.
// One write port, one registered read port. Depends on nothing.
module rpn_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rpn_alu.sv
// Bit-serial arithmetic unit: serial add/subtract, shift-add multiply,
// restoring divide (one quotient bit per cycle). Depends on rpn_pkg.
module rpn_alu
    import rpn_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_alu_ctrl         i_ctrl,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic              o_done,
    output logic [DATA_W-1:0] o_result
);

    localparam int CW = $clog2(DATA_W + 1);

    logic              r_busy;
    logic              r_fix;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    t_alu_op           r_op;
    logic [DATA_W-1:0] r_a;
    logic [DATA_W-1:0] r_b;
    logic [DATA_W-1:0] r_acc;
    logic [DATA_W:0]   r_rem;
    logic              r_carry;
    logic              r_neg;

    logic              bit_b;
    logic              sum_bit;
    logic              carry_n;
    logic [DATA_W:0]   rem_sh;
    logic [DATA_W:0]   rem_diff;
    logic              rem_ge;
    logic [DATA_W-1:0] mul_sum;

    always_comb begin
        bit_b    = r_b[0] ^ (r_op == ALU_SUB);
        sum_bit  = r_a[0] ^ bit_b ^ r_carry;
        carry_n  = (r_a[0] & bit_b) | (r_a[0] & r_carry) | (bit_b & r_carry);
        rem_sh   = {r_rem[DATA_W-1:0], r_a[DATA_W-1]};
        rem_diff = rem_sh - {1'b0, r_b};
        rem_ge   = ~rem_diff[DATA_W];
        mul_sum  = r_acc + r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_done  <= 1'b0;
                r_busy  <= 1'b1;
                r_fix   <= 1'b0;
                r_cnt   <= '0;
                r_op    <= i_ctrl.op;
                r_acc   <= '0;
                r_rem   <= '0;
                r_carry <= (i_ctrl.op == ALU_SUB);
                r_neg   <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
                if (i_ctrl.op == ALU_DIV) begin
                    // divide runs on magnitudes, sign applied afterwards
                    r_a <= i_a[DATA_W-1] ? (DATA_W'(0) - i_a) : i_a;
                    r_b <= i_b[DATA_W-1] ? (DATA_W'(0) - i_b) : i_b;
                end else begin
                    r_a <= i_a;
                    r_b <= i_b;
                end
            end else if (r_busy) begin
                if (r_cnt == CW'(DATA_W)) begin
                    r_busy <= 1'b0;
                    r_fix  <= (r_op == ALU_DIV) && r_neg;
                    r_done <= !((r_op == ALU_DIV) && r_neg);
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt + CW'(1);
                    case (r_op)
                        ALU_ADD, ALU_SUB: begin
                            r_acc   <= {sum_bit, r_acc[DATA_W-1:1]};
                            r_carry <= carry_n;
                            r_a     <= r_a >> 1;
                            r_b     <= r_b >> 1;
                        end
                        ALU_MUL: begin
                            if (r_b[0]) begin
                                r_acc <= mul_sum;
                            end
                            r_a <= r_a << 1;
                            r_b <= r_b >> 1;
                        end
                        ALU_DIV: begin
                            r_acc <= {r_acc[DATA_W-2:0], rem_ge};
                            r_rem <= rem_ge ? rem_diff : rem_sh;
                            r_a   <= r_a << 1;
                        end
                        default: begin
                            r_acc <= r_acc;
                        end
                    endcase
                end
            end else if (r_fix) begin
                r_acc  <= DATA_W'(0) - r_acc;
                r_fix  <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt <= CW'(DATA_W))
        else $error("alu step count past word width");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) || $past(r_fix)))
        else $error("alu done without preceding work");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.start |-> (!r_busy && !r_fix))
        else $error("alu started while busy");

endmodule

// File: src/rpn_stack_calculator_unit.sv
// Channel  | valid       | ready       | payload
// input    | i_in_valid  | o_in_ready  | i_mode, i_value
// output   | o_out_valid | i_out_ready | o_top_value, o_status, o_depth
//
// Push, read top and every error step pass from S_IDLE through S_DONE to the output register.
// Add, subtract, multiply, negate and divide also pass through S_ALU: the
// bit-serial unit spends one cycle per bit of the 32-bit word plus wrap-up, and a negative quotient adds a sign fix.
// One item is in work at a time; the next is accepted while a result waits.
// Reset (synchronous, active low) empties the stack; entries need no clearing.
// A stalled output holds the finished result; the item in work waits for it.
//
// Top level; depends on rpn_pkg, rpn_mem and rpn_alu.
module rpn_stack_calculator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [DATA_W-1:0]      i_value,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [DATA_W-1:0]      o_top_value,
    output logic [1:0]             o_status,
    output logic [DEPTH_OUT_W-1:0] o_depth
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALU,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic [DW-1:0]          r_depth;
    logic [DATA_W-1:0]      r_tos;
    logic [DATA_W-1:0]      r_nos;
    logic                   r_pop;
    t_status                r_status;
    logic                   r_out_valid;
    logic [DATA_W-1:0]      r_out_top;
    t_status                r_out_status;
    logic [DEPTH_OUT_W-1:0] r_out_depth;

    logic              in_accept;
    logic              has1;
    logic              has2;
    logic              has3;
    logic              full;
    logic [DW-1:0]     depth_m2;
    logic [DW-1:0]     depth_m3;
    t_status           dec_status;
    logic              do_push;
    logic              do_alu;
    t_alu_ctrl         alu_ctrl;
    logic [DATA_W-1:0] alu_a;
    logic              alu_done;
    logic [DATA_W-1:0] alu_result;
    logic              mem_we;
    logic              mem_re;
    logic [DATA_W-1:0] mem_rdata;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid & o_in_ready;

    assign has1     = (r_depth != '0);
    assign has2     = (r_depth >= DW'(2));
    assign has3     = (r_depth >= DW'(3));
    assign full     = (r_depth == DW'(STACK_DEPTH));
    assign depth_m2 = r_depth - DW'(2);
    assign depth_m3 = r_depth - DW'(3);

    always_comb begin
        dec_status  = ST_OK;
        do_push     = 1'b0;
        do_alu      = 1'b0;
        alu_ctrl.op = ALU_ADD;
        alu_a       = r_nos;
        case (i_mode)
            MODE_PUSH: begin
                if (full) begin
                    dec_status = ST_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (!has2) begin
                    dec_status = ST_UNDER;
                end else if (i_mode == MODE_DIV && r_tos == '0) begin
                    dec_status = ST_DIVZ;
                end else begin
                    do_alu = 1'b1;
                end
                case (i_mode)
                    MODE_SUB: alu_ctrl.op = ALU_SUB;
                    MODE_MUL: alu_ctrl.op = ALU_MUL;
                    MODE_DIV: alu_ctrl.op = ALU_DIV;
                    default:  alu_ctrl.op = ALU_ADD;
                endcase
            end
            MODE_NEG: begin
                // negate runs as 0 - top
                alu_ctrl.op = ALU_SUB;
                alu_a       = '0;
                if (!has1) begin
                    dec_status = ST_UNDER;
                end else begin
                    do_alu = 1'b1;
                end
            end
            default: begin
                if (!has1) begin
                    dec_status = ST_UNDER;
                end
            end
        endcase
        alu_ctrl.start = in_accept & do_alu;
    end

    // spill the second entry on push; prefetch the third entry on a pop
    assign mem_we = in_accept & do_push & has2;
    assign mem_re = in_accept & do_alu & (i_mode != MODE_NEG) & has3;

    rpn_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW),
        .DW    (DATA_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (depth_m2[AW-1:0]),
        .i_wdata (r_nos),
        .i_re    (mem_re),
        .i_raddr (depth_m3[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    rpn_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (alu_ctrl),
        .i_a      (alu_a),
        .i_b      (r_tos),
        .o_done   (alu_done),
        .o_result (alu_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_status <= dec_status;
                        r_pop    <= (i_mode != MODE_NEG);
                        if (do_push) begin
                            r_nos   <= r_tos;
                            r_tos   <= i_value;
                            r_depth <= r_depth + DW'(1);
                        end
                        r_state <= do_alu ? S_ALU : S_DONE;
                    end
                end
                S_ALU: begin
                    if (alu_done) begin
                        r_tos <= alu_result;
                        if (r_pop) begin
                            r_depth <= r_depth - DW'(1);
                            r_nos   <= mem_rdata;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_top    <= has1 ? r_tos : '0;
                        r_out_status <= r_status;
                        r_out_depth  <= DEPTH_OUT_W'(r_depth);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_top_value = r_out_top;
    assign o_status    = r_out_status;
    assign o_depth     = r_out_depth;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state != S_IDLE)
        else $error("accepted item left no work");

    a_alu_done_in_alu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_done |-> r_state == S_ALU)
        else $error("alu finished outside its state");

    a_push_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && do_push) |=> r_depth == $past(r_depth) + DW'(1))
        else $error("push did not grow the stack");

endmodule

// File: dv/rpn_stack_calculator_checker.sv
// Scoreboard for the RPN stack calculator: keeps its own operand stack, predicts each result.
// Compares accepted results in order and reports the failure count to the testbench top.
// Depends on rpn_pkg.
module rpn_stack_calculator_checker
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_ready,
    input  logic [MODE_W-1:0]      i_mode,
    input  logic [DATA_W-1:0]      i_value,
    input  logic                   i_out_valid,
    input  logic                   i_out_ready,
    input  logic [DATA_W-1:0]      i_top_value,
    input  logic [1:0]             i_status,
    input  logic [DEPTH_OUT_W-1:0] i_depth,
    output int                     o_pending,
    output int                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DATA_W-1:0]      top;
        t_status                status;
        logic [DEPTH_OUT_W-1:0] depth;
    } t_calc_result;

    logic [DATA_W-1:0] operand_mem [STACK_DEPTH];
    int unsigned       operand_count;
    t_calc_result      results_due [$];

    function automatic logic [DATA_W-1:0] div_toward_zero(input logic [DATA_W-1:0] num,
                                                          input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] mag_num;
        logic [DATA_W-1:0] mag_den;
        logic [DATA_W-1:0] quo;
        mag_num = num[DATA_W-1] ? -num : num;
        mag_den = den[DATA_W-1] ? -den : den;
        quo     = mag_num / mag_den;
        // most negative / -1 wraps back to itself through the unsigned magnitude
        return (num[DATA_W-1] ^ den[DATA_W-1]) ? -quo : quo;
    endfunction

    // Applies one item to the local stack and returns the result it must produce.
    function automatic t_calc_result evaluate_item(input logic [MODE_W-1:0] mode,
                                                   input logic [DATA_W-1:0] value);
        t_calc_result      res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] acc;
        res.status = ST_OK;
        case (mode)
            MODE_PUSH: begin
                if (operand_count >= STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    operand_mem[operand_count] = value;
                    operand_count++;
                end
            end
            MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
                if (operand_count < 2) begin
                    res.status = ST_UNDER;
                end else begin
                    rhs = operand_mem[operand_count-1];
                    lhs = operand_mem[operand_count-2];
                    if (mode == MODE_DIV && rhs == '0) begin
                        res.status = ST_DIVZ;
                    end else begin
                        case (mode)
                            MODE_ADD: acc = lhs + rhs;
                            MODE_SUB: acc = lhs - rhs;
                            MODE_MUL: acc = lhs * rhs;
                            default:  acc = div_toward_zero(lhs, rhs);
                        endcase
                        operand_count--;
                        operand_mem[operand_count-1] = acc;
                    end
                end
            end
            MODE_NEG: begin
                if (operand_count == 0) begin
                    res.status = ST_UNDER;
                end else begin
                    operand_mem[operand_count-1] = -operand_mem[operand_count-1];
                end
            end
            default: begin
                // read top, and the unused code that behaves the same
                if (operand_count == 0) begin
                    res.status = ST_UNDER;
                end
            end
        endcase
        res.top   = (operand_count == 0) ? '0 : operand_mem[operand_count-1];
        res.depth = DEPTH_OUT_W'(operand_count);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_calc_result due;
        if (!i_rst_n) begin
            operand_count = 0;
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT) begin
                        $display("%0t: result with none due: top=%h status=%0d depth=%0d",
                                 $realtime, i_top_value, i_status, i_depth);
                    end
                end else begin
                    due = results_due.pop_front();
                    if (i_top_value !== due.top || i_status !== due.status
                            || i_depth !== due.depth) begin
                        o_fail_count++;
                        if (o_fail_count <= REPORT_LIMIT) begin
                            $display({"%0t: mismatch: top exp %h got %h, ",
                                      "status exp %0d got %0d, depth exp %0d got %0d"},
                                     $realtime, due.top, i_top_value, due.status, i_status,
                                     due.depth, i_depth);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                results_due.push_back(evaluate_item(i_mode, i_value));
            end
        end
        o_pending = results_due.size();
    end

endmodule

// File: dv/tb_rpn_stack_calculator_unit.sv
// Testbench top for rpn_stack_calculator_unit: clock, reset, item stimulus, verdict.
// Prediction and checking live in rpn_stack_calculator_checker; depends on rpn_pkg.
module tb_rpn_stack_calculator_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rpn_pkg::*;

    localparam logic [MODE_W-1:0] MODE_RSVD = 3'd7;   // unused code, reads top
    localparam int RANDOM_ITEMS   = 620;
    localparam int FILL_BURST     = 66;               // enough pushes to overflow the stack
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [DATA_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [DATA_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    logic                   i_clk;
    logic                   i_rst_n     = 1'b0;
    logic                   i_in_valid  = 1'b0;
    logic                   o_in_ready;
    logic [MODE_W-1:0]      i_mode      = '0;
    logic [DATA_W-1:0]      i_value     = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [DATA_W-1:0]      o_top_value;
    logic [1:0]             o_status;
    logic [DEPTH_OUT_W-1:0] o_depth;

    int pending;
    int fail_count;
    int send_idle_pct = 33;
    int recv_idle_pct = 87;
    int fill_guess    = 0;    // rough stack depth, only used to shape stimulus
    int quiet_cycles  = 0;

    rpn_stack_calculator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_mode      (i_mode),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_top_value (o_top_value),
        .o_status    (o_status),
        .o_depth     (o_depth)
    );

    rpn_stack_calculator_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_top_value  (o_top_value),
        .i_status     (o_status),
        .i_depth      (o_depth),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("rpn_stack_calculator_unit regression: fail");
            $finish;
        end
    end

    function automatic logic [DATA_W-1:0] pick_operand();
        case ($urandom_range(9))
            0:       return '0;
            1:       return INT_MIN;
            2:       return INT_MAX;
            3:       return '1;
            4, 5:    return DATA_W'($urandom_range(32)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_value    <= value;
        do @(posedge i_clk); while (!o_in_ready);
        if (mode == MODE_PUSH) begin
            if (fill_guess < STACK_DEPTH_DEF) fill_guess++;
        end else if (mode >= MODE_ADD && mode <= MODE_DIV) begin
            if (fill_guess >= 2) fill_guess--;
        end
    endtask

    task automatic send_random_op();
        int                pick;
        logic [MODE_W-1:0] mode;
        pick = $urandom_range(99);
        if (pick < 3) begin
            mode = MODE_RSVD;
        end else if (pick < 8) begin
            mode = MODE_READ;
        end else if (pick < 15) begin
            mode = MODE_NEG;
        end else if (pick < 55) begin
            mode = MODE_PUSH;
        end else begin
            case ($urandom_range(3))
                0:       mode = MODE_ADD;
                1:       mode = MODE_SUB;
                2:       mode = MODE_MUL;
                default: mode = MODE_DIV;
            endcase
        end
        // keep most operations legal so expressions get evaluated, leave some underflows
        if (((mode >= MODE_ADD && mode <= MODE_DIV && fill_guess < 2) || fill_guess == 0)
                && $urandom_range(9) != 0) begin
            mode = MODE_PUSH;
        end
        send_item(mode, pick_operand());
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // underflow on the empty stack
        send_item(MODE_READ, 32'h0);
        send_item(MODE_NEG, 32'hFFFF_FFFF);
        send_item(MODE_ADD, 32'h0);
        send_item(MODE_PUSH, INT_MAX);
        send_item(MODE_SUB, 32'h0);        // one entry is not enough
        // wraparound cases
        send_item(MODE_PUSH, 32'd1);
        send_item(MODE_ADD, 32'h0);        // max + 1 wraps to min
        send_item(MODE_PUSH, 32'hFFFF_FFFF);
        send_item(MODE_DIV, 32'h0);        // min / -1 wraps to min
        send_item(MODE_NEG, 32'h0);        // -min stays min
        send_item(MODE_PUSH, 32'h0);
        send_item(MODE_DIV, 32'h0);        // divide by zero, stack kept
        send_item(MODE_RSVD, 32'h5A5A_5A5A);
        // truncation toward zero, mul and sub
        send_item(MODE_PUSH, 32'd7);
        send_item(MODE_PUSH, 32'hFFFF_FFFE);
        send_item(MODE_DIV, 32'h0);
        send_item(MODE_PUSH, 32'hDEAD_BEEF);
        send_item(MODE_MUL, 32'h0);
        send_item(MODE_SUB, 32'h0);
        send_item(MODE_READ, 32'h0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 87;
                recv_idle_pct = 33;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 250 == 120) begin
                repeat (FILL_BURST) send_item(MODE_PUSH, pick_operand());
            end
            send_random_op();
        end
        i_in_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("rpn_stack_calculator_unit regression: pass");
        end else begin
            $display("rpn_stack_calculator_unit regression: fail");
        end
        $finish;
    end

endmodule

// File: files.f
src/rpn_pkg.sv
src/rpn_mem.sv
src/rpn_alu.sv
src/rpn_stack_calculator_unit.sv
dv/rpn_stack_calculator_checker.sv
dv/tb_rpn_stack_calculator_unit.sv
